// ===== hw/rtl/tbn_pkg.sv =====
`timescale 1ns / 1ps

package tbn_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 24;
    localparam int unsigned SEEN_W  = 25;
    localparam int unsigned REG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [SEEN_W-1:0]  SEEN_MAX = '1;
    localparam logic [COUNT_W-1:0] RUN_MAX  = '1;

    localparam logic [COUNT_W-1:0] SIZE_LIMIT_RESET = 24'd1048576;

    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [BYTE_W-1:0] UTF8_CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] UTF8_CONT_BITS  = 8'h80;
    localparam logic [BYTE_W-1:0] UTF8_LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] UTF8_LEAD2_BITS = 8'hC0;
    localparam logic [BYTE_W-1:0] UTF8_LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] UTF8_LEAD3_BITS = 8'hE0;
    localparam logic [BYTE_W-1:0] UTF8_LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] UTF8_LEAD4_BITS = 8'hF0;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SIZE_LIMIT     = 2'd0,
        REG_FOLD_ENDINGS   = 2'd1,
        REG_TRIM_ENABLE    = 2'd2,
        REG_CHECK_ENCODING = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        OUTCOME_OK        = 2'd0,
        OUTCOME_TOO_LARGE = 2'd1,
        OUTCOME_BAD_UTF8  = 2'd2
    } outcome_t;

    typedef struct packed {
        logic [COUNT_W-1:0] size_limit;
        logic               fold_line_endings;
        logic               trim_enable;
        logic               check_encoding;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] body_byte;
        logic              final_byte;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  text_byte;
        logic               has_byte;
        logic               end_of_body;
        logic [COUNT_W-1:0] tail_trim_count;
        logic [1:0]         outcome;
    } out_word_t;

    // one accepted byte after classification: optional byte, optional status
    typedef struct packed {
        logic [BYTE_W-1:0]  text_byte;
        logic               has_byte;
        logic               fin;
        logic [COUNT_W-1:0] tail_trim_count;
        outcome_t           outcome;
    } entry_t;

endpackage

// ===== hw/rtl/text_body_normalize_trim_utf8_check_top.sv =====
`timescale 1ns / 1ps

// Text body normalizer. Body bytes go in one per push; with folding on, each
// byte is folded (CR LF and lone CR become LF), leading whitespace is dropped
// when trimming is on, and emitted bytes are checked for UTF-8 lead/continuation
// structure. A byte gives zero or one byte word; a byte marked final also
// gives a status word with the trailing whitespace count to cut and the
// outcome (too large wins over invalid UTF-8). The front accepts one byte per
// cycle with no bubbles; the back hands out one word per cycle, so a final
// byte that also emits a byte gives two words on the output side. A small
// queue between the two absorbs that and any output stall; the input backs
// up only when it fills. Registers may be written only while the block is idle.
module text_body_normalize_trim_utf8_check_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  tbn_pkg::in_word_t                in_word,
    output logic                             empty,
    input  logic                             pop,
    output tbn_pkg::out_word_t               out_word,
    input  logic                             cfg_we,
    input  logic [tbn_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [tbn_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tbn_pkg::cfg_t   cfg_reg;
    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_nonempty;
    tbn_pkg::entry_t wr_entry;
    tbn_pkg::entry_t rd_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_limit        <= tbn_pkg::SIZE_LIMIT_RESET;
            cfg_reg.fold_line_endings <= 1'b1;
            cfg_reg.trim_enable       <= 1'b1;
            cfg_reg.check_encoding    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (tbn_pkg::reg_idx_t'(cfg_index))
                tbn_pkg::REG_SIZE_LIMIT:     cfg_reg.size_limit        <= cfg_data;
                tbn_pkg::REG_FOLD_ENDINGS:   cfg_reg.fold_line_endings <= cfg_data[0];
                tbn_pkg::REG_TRIM_ENABLE:    cfg_reg.trim_enable       <= cfg_data[0];
                tbn_pkg::REG_CHECK_ENCODING: cfg_reg.check_encoding    <= cfg_data[0];
                default:                     cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    tbn_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_word (in_word),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .full    (full),
        .q_push  (q_push),
        .q_entry (wr_entry)
    );

    tbn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (q_push),
        .wr_entry   (wr_entry),
        .q_full     (q_full),
        .rd_en      (q_pop),
        .q_nonempty (q_nonempty),
        .rd_entry   (rd_entry)
    );

    tbn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_entry    (rd_entry),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .out_word   (out_word)
    );

endmodule

// ===== hw/rtl/tbn_front.sv =====
`timescale 1ns / 1ps

module tbn_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tbn_pkg::in_word_t in_word,
    input  tbn_pkg::cfg_t    cfg,
    input  logic             q_full,
    output logic             full,
    output logic             q_push,
    output tbn_pkg::entry_t  q_entry
);

    logic [tbn_pkg::SEEN_W-1:0]  bytes_seen_reg, bytes_seen_next;
    logic                        after_cr_reg, after_cr_next;
    logic                        content_started_reg, content_started_next;
    logic [tbn_pkg::COUNT_W-1:0] tail_run_reg, tail_run_next;
    logic [1:0]                  cont_due_reg, cont_due_next;
    logic                        enc_bad_reg, enc_bad_next;

    logic                        accept;
    logic [tbn_pkg::BYTE_W-1:0]  b;
    logic                        emit;
    logic                        ws;
    logic [tbn_pkg::SEEN_W-1:0]  seen_inc;
    logic [tbn_pkg::COUNT_W-1:0] run_upd;
    logic [1:0]                  due_upd;
    logic                        bad_upd;
    logic                        fin;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign fin    = in_word.final_byte;

    always_comb
    begin
        seen_inc = (bytes_seen_reg == tbn_pkg::SEEN_MAX) ? bytes_seen_reg
                                                          : bytes_seen_reg + 1'b1;
        b             = in_word.body_byte;
        emit          = 1'b1;
        after_cr_next = 1'b0;
        if (cfg.fold_line_endings)
        begin
            if (b == tbn_pkg::CHAR_CR)
            begin
                b             = tbn_pkg::CHAR_LF;
                after_cr_next = 1'b1;
            end
            else if (b == tbn_pkg::CHAR_LF && after_cr_reg)
            begin
                emit = 1'b0;
            end
        end

        ws = (b == tbn_pkg::CHAR_SPACE) || (b >= tbn_pkg::CHAR_TAB && b <= tbn_pkg::CHAR_CR);

        if (cfg.trim_enable && !content_started_reg && ws)
            emit = 1'b0;

        run_upd              = tail_run_reg;
        content_started_next = content_started_reg;
        due_upd              = cont_due_reg;
        bad_upd              = enc_bad_reg;

        if (emit)
        begin
            if (ws)
            begin
                if (tail_run_reg != tbn_pkg::RUN_MAX)
                    run_upd = tail_run_reg + 1'b1;
            end
            else
            begin
                run_upd              = '0;
                content_started_next = 1'b1;
            end

            // lenient utf-8 lead / continuation structure
            if ((b & tbn_pkg::UTF8_CONT_MASK) == tbn_pkg::UTF8_CONT_BITS)
            begin
                if (cont_due_reg != 2'd0)
                    due_upd = cont_due_reg - 2'd1;
                else
                    bad_upd = 1'b1;
            end
            else
            begin
                if (cont_due_reg != 2'd0)
                    bad_upd = 1'b1;
                priority if (b[7] == 1'b0)
                    due_upd = 2'd0;
                else if ((b & tbn_pkg::UTF8_LEAD2_MASK) == tbn_pkg::UTF8_LEAD2_BITS)
                    due_upd = 2'd1;
                else if ((b & tbn_pkg::UTF8_LEAD3_MASK) == tbn_pkg::UTF8_LEAD3_BITS)
                    due_upd = 2'd2;
                else if ((b & tbn_pkg::UTF8_LEAD4_MASK) == tbn_pkg::UTF8_LEAD4_BITS)
                    due_upd = 2'd3;
                else
                begin
                    due_upd = 2'd0;
                    bad_upd = 1'b1;
                end
            end
        end

        q_entry.text_byte       = b;
        q_entry.has_byte        = emit;
        q_entry.fin             = fin;
        q_entry.tail_trim_count = cfg.trim_enable ? run_upd : '0;
        priority if (seen_inc > {1'b0, cfg.size_limit})
            q_entry.outcome = tbn_pkg::OUTCOME_TOO_LARGE;
        else if (cfg.check_encoding && (bad_upd || due_upd != 2'd0))
            q_entry.outcome = tbn_pkg::OUTCOME_BAD_UTF8;
        else
            q_entry.outcome = tbn_pkg::OUTCOME_OK;

        q_push = accept && (emit || fin);

        if (fin)
        begin
            bytes_seen_next      = '0;
            after_cr_next        = 1'b0;
            content_started_next = 1'b0;
            tail_run_next        = '0;
            cont_due_next        = 2'd0;
            enc_bad_next         = 1'b0;
        end
        else
        begin
            bytes_seen_next = seen_inc;
            tail_run_next   = run_upd;
            cont_due_next   = due_upd;
            enc_bad_next    = bad_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg      <= '0;
            after_cr_reg        <= 1'b0;
            content_started_reg <= 1'b0;
            tail_run_reg        <= '0;
            cont_due_reg        <= 2'd0;
            enc_bad_reg         <= 1'b0;
        end
        else if (accept)
        begin
            bytes_seen_reg      <= bytes_seen_next;
            after_cr_reg        <= after_cr_next;
            content_started_reg <= content_started_next;
            tail_run_reg        <= tail_run_next;
            cont_due_reg        <= cont_due_next;
            enc_bad_reg         <= enc_bad_next;
        end
    end

endmodule

// ===== hw/rtl/tbn_queue.sv =====
`timescale 1ns / 1ps

module tbn_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  tbn_pkg::entry_t wr_entry,
    output logic            q_full,
    input  logic            rd_en,
    output logic            q_nonempty,
    output tbn_pkg::entry_t rd_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tbn_pkg::entry_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_full     = (count_reg == CNT_FULL);
    assign q_nonempty = (count_reg != '0);
    assign rd_entry   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/tbn_back.sv =====
`timescale 1ns / 1ps

module tbn_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_nonempty,
    input  tbn_pkg::entry_t    q_entry,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output tbn_pkg::out_word_t out_word
);

    tbn_pkg::entry_t cur_reg;
    logic            cur_valid_reg, cur_valid_next;
    logic            byte_pending_reg, byte_pending_next;
    logic            taken;
    logic            done;

    assign empty = !cur_valid_reg;
    assign taken = pop && cur_valid_reg;
    // word finished with this entry: a lone byte, or the status word
    assign done  = taken && (!byte_pending_reg || !cur_reg.fin);
    assign q_pop = q_nonempty && (!cur_valid_reg || done);

    always_comb
    begin
        cur_valid_next    = cur_valid_reg;
        byte_pending_next = byte_pending_reg;
        if (q_pop)
        begin
            cur_valid_next    = 1'b1;
            byte_pending_next = q_entry.has_byte;
        end
        else if (done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (taken)
        begin
            byte_pending_next = 1'b0;
        end

        if (byte_pending_reg)
        begin
            out_word.text_byte       = cur_reg.text_byte;
            out_word.has_byte        = 1'b1;
            out_word.end_of_body     = 1'b0;
            out_word.tail_trim_count = '0;
            out_word.outcome         = tbn_pkg::OUTCOME_OK;
        end
        else
        begin
            out_word.text_byte       = '0;
            out_word.has_byte        = 1'b0;
            out_word.end_of_body     = 1'b1;
            out_word.tail_trim_count = cur_reg.tail_trim_count;
            out_word.outcome         = cur_reg.outcome;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg    <= 1'b0;
            byte_pending_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg    <= cur_valid_next;
            byte_pending_reg <= byte_pending_next;
        end
    end

endmodule
